// File: src/mm3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_pkg
// Shared constants, types and helpers of the 32-bit string hash block.
// ----------------------------------------------------------------------------
package mm3_pkg;

	localparam logic [31:0] K1_MUL_A   = 32'hcc9e2d51;
	localparam logic [31:0] K1_MUL_B   = 32'h1b873593;
	localparam logic [31:0] FIN_MUL_A  = 32'h85ebca6b;
	localparam logic [31:0] FIN_MUL_B  = 32'hc2b2ae35;
	localparam logic [31:0] H1_ADD     = 32'he6546b64;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	// one queued job for the mixing engine
	typedef struct packed {
		logic [7:0]  lo_byte;
		logic [7:0]  hi_byte;
		logic        has_k;
		logic        pair;
		logic        finish;
		logic [31:0] len;
	} mm3_entry_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_K1,
		B_K2,
		B_MIX,
		B_F1,
		B_F2,
		B_OUT
	} mm3_state_t;

	function automatic logic [31:0] rotl15(input logic [31:0] v);
		return {v[16:0], v[31:17]};
	endfunction

	function automatic logic [31:0] rotl13(input logic [31:0] v);
		return {v[18:0], v[31:19]};
	endfunction

endpackage
`default_nettype wire

// File: src/mm3_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_front
// Takes input bytes, pairs them up and queues one mixing job per pair or
// per string end.
// ----------------------------------------------------------------------------
module mm3_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire  [7:0]           data_byte,
	input  wire                  last_item,
	input  wire                  no_byte,
	input  wire                  q_full,
	output logic                 q_push,
	output mm3_pkg::mm3_entry_t  q_entry
);

	logic        accept;
	logic        pair;
	logic [7:0]  held_q;
	logic        waiting_q;
	logic [30:0] count_q;
	logic [30:0] count_nx;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign pair     = waiting_q && !no_byte;
	// only bit 30 and below of the count reach the length after doubling
	assign count_nx = no_byte ? count_q : count_q + 31'd1;

	always_comb begin
		q_entry.lo_byte = waiting_q ? held_q : data_byte;
		q_entry.hi_byte = pair ? data_byte : 8'd0;
		q_entry.has_k   = waiting_q || (!no_byte && last_item);
		q_entry.pair    = pair;
		q_entry.finish  = last_item;
		q_entry.len     = {count_nx, 1'b0};
		q_push          = accept && (last_item || pair);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q <= 1'b0;
			count_q   <= '0;
			held_q    <= '0;
		end else if (accept) begin
			if (last_item) begin
				waiting_q <= 1'b0;
				count_q   <= '0;
				held_q    <= '0;
			end else if (!no_byte) begin
				count_q <= count_nx;
				if (waiting_q) begin
					waiting_q <= 1'b0;
				end else begin
					held_q    <= data_byte;
					waiting_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: src/mm3_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_queue
// Short first-in first-out queue of mixing jobs between front and back.
// ----------------------------------------------------------------------------
module mm3_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  mm3_pkg::mm3_entry_t  push_entry,
	input  wire                  pop,
	output mm3_pkg::mm3_entry_t  head_entry,
	output logic                 full,
	output logic                 empty
);

	mm3_pkg::mm3_entry_t               mem_q [mm3_pkg::QUEUE_DEPTH];
	logic [mm3_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [mm3_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [mm3_pkg::QPTR_W:0]          fill_q;

	assign full       = (fill_q == (mm3_pkg::QPTR_W+1)'(mm3_pkg::QUEUE_DEPTH));
	assign empty      = (fill_q == '0);
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + mm3_pkg::QPTR_W'(1);
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + mm3_pkg::QPTR_W'(1);
			end
			case ({push && !full, pop && !empty})
				2'b10:   fill_q <= fill_q + (mm3_pkg::QPTR_W+1)'(1);
				2'b01:   fill_q <= fill_q - (mm3_pkg::QPTR_W+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: src/mm3_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_back
// Mixing engine: runs each queued job through one shared multiplier, keeps
// the running hash and finalizes it into the output register.
// ----------------------------------------------------------------------------
module mm3_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  q_empty,
	input  mm3_pkg::mm3_entry_t  q_entry,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire                  out_stall,
	output logic [31:0]          hash_value
);

	mm3_pkg::mm3_state_t state_q, state_nx;
	mm3_pkg::mm3_entry_t job_q;
	logic [31:0]         acc_q;
	logic [31:0]         hash_q;
	logic                out_valid_q;
	logic [31:0]         out_hash_q;
	logic [31:0]         mul_a;
	logic [31:0]         mul_b;
	logic [31:0]         prod;
	logic [31:0]         fin_x;
	logic [31:0]         fin_y;
	logic [31:0]         mixed;
	logic                out_free;

	assign out_valid  = out_valid_q;
	assign hash_value = out_hash_q;
	assign out_free   = !out_valid_q || !out_stall;

	assign fin_x = hash_q ^ job_q.len;
	assign fin_y = acc_q ^ (acc_q >> 13);
	assign mixed = mm3_pkg::rotl13(hash_q ^ acc_q);
	assign prod  = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mm3_pkg::B_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		q_pop    = 1'b0;
		mul_a    = {16'd0, job_q.hi_byte, 8'd0} << 8 | {24'd0, job_q.lo_byte};
		mul_b    = mm3_pkg::K1_MUL_A;
		case (state_q)
			mm3_pkg::B_IDLE: begin
				if (!q_empty) begin
					q_pop    = 1'b1;
					state_nx = q_entry.has_k ? mm3_pkg::B_K1 : mm3_pkg::B_F1;
				end
			end
			mm3_pkg::B_K1: begin
				state_nx = mm3_pkg::B_K2;
			end
			mm3_pkg::B_K2: begin
				mul_a    = mm3_pkg::rotl15(acc_q);
				mul_b    = mm3_pkg::K1_MUL_B;
				state_nx = mm3_pkg::B_MIX;
			end
			mm3_pkg::B_MIX: begin
				state_nx = job_q.finish ? mm3_pkg::B_F1 : mm3_pkg::B_IDLE;
			end
			mm3_pkg::B_F1: begin
				mul_a    = fin_x ^ (fin_x >> 16);
				mul_b    = mm3_pkg::FIN_MUL_A;
				state_nx = mm3_pkg::B_F2;
			end
			mm3_pkg::B_F2: begin
				mul_a    = fin_y;
				mul_b    = mm3_pkg::FIN_MUL_B;
				state_nx = mm3_pkg::B_OUT;
			end
			mm3_pkg::B_OUT: begin
				if (out_free) begin
					state_nx = mm3_pkg::B_IDLE;
				end
			end
			default: begin
				state_nx = mm3_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == mm3_pkg::B_IDLE && !q_empty) begin
			job_q <= q_entry;
		end
		if (state_q == mm3_pkg::B_K1 || state_q == mm3_pkg::B_K2 ||
		    state_q == mm3_pkg::B_F1 || state_q == mm3_pkg::B_F2) begin
			acc_q <= prod;
		end
		if (state_q == mm3_pkg::B_OUT && out_free) begin
			out_hash_q <= acc_q ^ (acc_q >> 16);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == mm3_pkg::B_MIX) begin
				// a tail byte is xored in without the h1 mix
				hash_q <= job_q.pair ? mixed + (mixed << 2) + mm3_pkg::H1_ADD
				                     : hash_q ^ acc_q;
			end else if (state_q == mm3_pkg::B_OUT && out_free) begin
				hash_q <= '0;
			end
			if (state_q == mm3_pkg::B_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: src/murmur3_char_pair_string_hash.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// murmur3_char_pair_string_hash
// 32-bit string hash over a byte stream, two bytes to a mixed word.
// ----------------------------------------------------------------------------
// Input channel: one word per string byte (data_byte, last_item, no_byte),
// taken at an edge with in_valid high and in_stall low. Raise last_item on
// the final byte, or send no_byte with last_item for an empty string.
// Output channel: one hash_value per string, held while out_stall is high.
// The front pairs bytes and takes one word a cycle while its four-job queue
// has room; in_stall is high only when that queue is full.
// The back mixes with one shared 32x32 multiplier: a byte pair passes
// through the K1, K2 and mix steps before the back takes its next job.
// After the last word, a job that leaves nothing to mix (empty string, or
// an even count closed by an empty word) goes through the F1, F2 and output
// steps; one that mixes in a byte pair or a tail byte first goes through K1,
// K2 and mix before them. Jobs still queued ahead of it are served first.
// A stalled result holds the back in its output step; the queue keeps
// filling until full. Reset clears the queue, the held byte, the count,
// the running hash and out_valid.
// ----------------------------------------------------------------------------
module murmur3_char_pair_string_hash (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  data_byte,
	input  wire         last_item,
	input  wire         no_byte,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [31:0] hash_value
);

	mm3_pkg::mm3_entry_t push_entry;
	mm3_pkg::mm3_entry_t head_entry;
	logic                push;
	logic                pop;
	logic                full;
	logic                empty;

	mm3_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.last_item (last_item),
		.no_byte   (no_byte),
		.q_full    (full),
		.q_push    (push),
		.q_entry   (push_entry)
	);

	mm3_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_entry (head_entry),
		.full       (full),
		.empty      (empty)
	);

	mm3_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (empty),
		.q_entry    (head_entry),
		.q_pop      (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value)
	);

endmodule
`default_nettype wire

// File: src/mm3_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_checker
// Port-level checks of the string hash block, bound to its top level.
// ----------------------------------------------------------------------------
module mm3_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        last_item,
	input wire        out_valid,
	input wire        out_stall,
	input wire [31:0] hash_value
);

	logic [3:0] pend_q;
	logic       last_in;
	logic       word_out;

	assign last_in  = in_valid && !in_stall && last_item;
	assign word_out = out_valid && !out_stall;

	// count strings ended on the input but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({last_in, word_out})
				2'b10:   pend_q <= pend_q + 4'd1;
				2'b01:   pend_q <= pend_q - 4'd1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hash_value))
		else $error("stalled hash changed or dropped");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 4'd0)
		else $error("hash shown with no string ended");

	// reset has taken effect by the edge after it is seen low
	a_reset_out: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result valid after reset");

	a_reset_in: assert property (@(posedge clk)
		!arst_n |=> !in_stall)
		else $error("input stalled after reset");

endmodule

bind murmur3_char_pair_string_hash mm3_checker u_mm3_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.last_item  (last_item),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.hash_value (hash_value)
);
`default_nettype wire

// File: sim/murmur3_char_pair_string_hash_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur3_char_pair_string_hash_chk
// Watches both channels of the string hash block, works out the hash of every
// string that enters and compares it, in order, with each word that leaves.
// ----------------------------------------------------------------------------
module murmur3_char_pair_string_hash_chk (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire         in_stall,
	input  wire  [7:0]  data_byte,
	input  wire         last_item,
	input  wire         no_byte,
	input  wire         out_valid,
	input  wire         out_stall,
	input  wire  [31:0] hash_value,
	output int          fail_count,
	output int          hashes_owed
);

	// running state of the string in flight
	logic [31:0] acc_hash   = '0;
	logic [7:0]  pend_byte  = '0;
	logic        pend_valid = 1'b0;
	logic [31:0] byte_total = '0;

	logic [31:0] expected_hashes[$];
	logic [31:0] want;
	int          fails = 0;
	int          owed  = 0;

	assign fail_count  = fails;
	assign hashes_owed = owed;

	function automatic logic [31:0] rot_left(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic logic [31:0] mix_key(input logic [31:0] k);
		logic [31:0] t;
		t = k * mm3_pkg::K1_MUL_A;
		t = rot_left(t, 15);
		return t * mm3_pkg::K1_MUL_B;
	endfunction

	function automatic logic [31:0] fold_key(input logic [31:0] h, input logic [31:0] k);
		logic [31:0] t;
		t = rot_left(h ^ k, 13);
		return t * 32'd5 + mm3_pkg::H1_ADD;
	endfunction

	function automatic logic [31:0] avalanche(input logic [31:0] h);
		logic [31:0] t;
		t = h ^ (h >> 16);
		t = t * mm3_pkg::FIN_MUL_A;
		t = t ^ (t >> 13);
		t = t * mm3_pkg::FIN_MUL_B;
		return t ^ (t >> 16);
	endfunction

	task automatic clear_string();
		acc_hash   = '0;
		pend_byte  = '0;
		pend_valid = 1'b0;
		byte_total = '0;
	endtask

	task automatic take_word(input logic [7:0] b, input logic last, input logic nb);
		logic [31:0] h;
		if (!nb) begin
			if (pend_valid) begin
				// first byte low, second byte in bits 16-23
				acc_hash   = fold_key(acc_hash, mix_key({8'h00, b, 8'h00, pend_byte}));
				pend_valid = 1'b0;
				pend_byte  = '0;
			end else begin
				pend_byte  = b;
				pend_valid = 1'b1;
			end
			byte_total = byte_total + 32'd1;
		end
		if (last) begin
			h = acc_hash;
			// odd tail: mix the key, skip the fold
			if (pend_valid)
				h = h ^ mix_key({24'h0, pend_byte});
			expected_hashes.push_back(avalanche(h ^ (byte_total << 1)));
			clear_string();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_string();
		end else begin
			// results always belong to earlier words, so check before predicting
			if (out_valid && !out_stall) begin
				if (expected_hashes.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: hash_value %08h with no string outstanding",
							$time, hash_value);
				end else begin
					want = expected_hashes.pop_front();
					if (hash_value !== want) begin
						fails++;
						if (fails <= 10)
							$display("%0t: hash_value expected %08h, got %08h",
								$time, want, hash_value);
					end
				end
			end
			if (in_valid && !in_stall)
				take_word(data_byte, last_item, no_byte);
			owed = expected_hashes.size();
		end
	end

endmodule

// File: sim/murmur3_char_pair_string_hash_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur3_char_pair_string_hash_tb
// Feeds strings byte by byte into the hash block: a directed set of edge
// strings, then random strings under three sender/receiver idle mixes. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module murmur3_char_pair_string_hash_tb;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 32;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [7:0]  data_byte = '0;
	logic        last_item = 1'b0;
	logic        no_byte   = 1'b0;
	logic        out_stall = 1'b0;
	wire         in_stall;
	wire         out_valid;
	wire  [31:0] hash_value;

	int fail_count;
	int hashes_owed;
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int words_sent   = 0;

	murmur3_char_pair_string_hash dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.last_item  (last_item),
		.no_byte    (no_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value)
	);

	murmur3_char_pair_string_hash_chk chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.last_item   (last_item),
		.no_byte     (no_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hash_value  (hash_value),
		.fail_count  (fail_count),
		.hashes_owed (hashes_owed)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < rx_stall_pct);
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("murmur3_char_pair_string_hash_tb: FAIL");
		$finish;
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_word(input logic [7:0] b, input logic last, input logic nb);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_item <= last;
		no_byte   <= nb;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		while (hashes_owed != 0) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic send_string(input int len);
		bit tail_on_byte;
		tail_on_byte = (len > 0) && ($urandom_range(99) < 60);
		for (int i = 0; i < len; i++) begin
			// stray empty word mid-string: the block must drop it
			if ($urandom_range(99) < 6)
				send_word(8'($urandom), 1'b0, 1'b1);
			send_word(8'($urandom), tail_on_byte && (i == len - 1), 1'b0);
			words_sent++;
		end
		if (!tail_on_byte) begin
			send_word(8'($urandom), 1'b1, 1'b1);
			words_sent++;
		end
	endtask

	task automatic run_phase(input int tx_pct, input int rx_pct, input int n_words);
		int stop_at;
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		stop_at      = words_sent + n_words;
		while (words_sent < stop_at) begin
			if ($urandom_range(99) < 4)
				send_string($urandom_range(9, 40));
			else
				send_string($urandom_range(0, 8));
			if ($urandom_range(99) < 5)
				hold_until_drained();
		end
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		tx_idle_pct  = 20;
		rx_stall_pct = 30;
		// empty string
		send_word(8'h00, 1'b1, 1'b1);
		// single bytes at both extremes
		send_word(8'h00, 1'b1, 1'b0);
		send_word(8'hff, 1'b1, 1'b0);
		// one pair, every bit toggled
		send_word(8'haa, 1'b0, 1'b0);
		send_word(8'h55, 1'b1, 1'b0);
		// odd length ending on a byte
		send_word(8'h01, 1'b0, 1'b0);
		send_word(8'h80, 1'b0, 1'b0);
		send_word(8'h7f, 1'b1, 1'b0);
		// stray empty word inside a pair, then an empty closing word
		send_word(8'h3c, 1'b0, 1'b0);
		send_word(8'hff, 1'b0, 1'b1);
		send_word(8'hc3, 1'b0, 1'b0);
		send_word(8'hff, 1'b1, 1'b1);
		// held byte closed by an empty word
		send_word(8'h96, 1'b0, 1'b0);
		send_word(8'h00, 1'b1, 1'b1);
		// stray empty word before the first byte
		send_word(8'h5a, 1'b0, 1'b1);
		send_word(8'ha5, 1'b1, 1'b0);
		send_word(8'h12, 1'b0, 1'b0);
		send_word(8'h34, 1'b0, 1'b0);
		send_word(8'h56, 1'b0, 1'b0);
		send_word(8'h78, 1'b0, 1'b0);
		send_word(8'h9a, 1'b1, 1'b0);
		hold_until_drained();

		run_phase(37, 84, 165);
		hold_until_drained();
		run_phase(84, 37, 165);
		hold_until_drained();
		run_phase(0, 0, 165);

		in_valid <= 1'b0;
		@(negedge clk);
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (fail_count == 0 && hashes_owed == 0)
			$display("murmur3_char_pair_string_hash_tb: PASS");
		else
			$display("murmur3_char_pair_string_hash_tb: FAIL");
		$finish;
	end

endmodule
